// File: hw/rtl/mve_pkg.sv
`default_nettype none
package mve_pkg;

   localparam int BYTE_W      = 8;
   localparam int VALUE_W     = 64;
   localparam int MAX_PAYLOAD = VALUE_W / BYTE_W;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      OP_INT = 2'd0,
      OP_STR = 2'd1,
      OP_BIN = 2'd2,
      OP_RAW = 2'd3
   } op_type;

   localparam logic [BYTE_W-1:0] HDR_FIXSTR = 8'ha0;
   localparam logic [BYTE_W-1:0] HDR_STR8   = 8'hd9;
   localparam logic [BYTE_W-1:0] HDR_STR16  = 8'hda;
   localparam logic [BYTE_W-1:0] HDR_STR32  = 8'hdb;
   localparam logic [BYTE_W-1:0] HDR_BIN8   = 8'hc4;
   localparam logic [BYTE_W-1:0] HDR_BIN16  = 8'hc5;
   localparam logic [BYTE_W-1:0] HDR_BIN32  = 8'hc6;
   localparam logic [BYTE_W-1:0] HDR_INT8   = 8'hd0;
   localparam logic [BYTE_W-1:0] HDR_INT16  = 8'hd1;
   localparam logic [BYTE_W-1:0] HDR_INT32  = 8'hd2;
   localparam logic [BYTE_W-1:0] HDR_INT64  = 8'hd3;

   // one classified word: header byte, payload byte count, payload msb-aligned
   typedef struct packed {
      logic [BYTE_W-1:0]  header;
      logic [CNT_W-1:0]   count;
      logic [VALUE_W-1:0] payload;
   } desc_type;

endpackage
`default_nettype wire

// File: hw/rtl/msgpack_value_encoder.sv
// MessagePack value encoder. Each accepted request (signed integer, string
// length, binary length or raw byte) is classified in the same cycle and
// queued; the serializer then sends its bytes one per cycle while rsp_stall
// is low on the rsp channel, header first and payload big-endian, with
// rsp_last_byte on the final byte. An item is 1 to 9 bytes: 1 for fixint,
// fixstr and raw bytes, 2/3/5/9 for the 8/16/32/64-bit forms. A string or
// binary length that is negative or above 4294967295 is dropped with no
// output. Requests keep being taken while the serializer works, until the
// two-entry queue is full.
`default_nettype none
module msgpack_value_encoder (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_operation,
   input  wire logic signed [63:0]  req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_byte
);

   mve_pkg::desc_type push_desc;
   mve_pkg::desc_type head;
   logic              push, pop, full, empty;

   mve_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .q_full        (full),
      .push          (push),
      .push_desc     (push_desc)
   );

   mve_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   mve_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
`default_nettype wire

// File: hw/rtl/mve_front.sv
`default_nettype none
module mve_front (
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_operation,
   input  wire logic signed [63:0]          req_value,
   input  wire logic                        q_full,
   output logic                             push,
   output mve_pkg::desc_type                push_desc
);

   logic [63:0]                 v;
   logic                        drop;
   logic [mve_pkg::BYTE_W-1:0]  header;
   logic [mve_pkg::CNT_W-1:0]   count;
   logic                        fixint, fit8, fit16, fit32;
   logic                        len_bad, len_lt32, len_le8, len_le16;

   assign v        = req_value;
   assign fixint   = (~|v[63:7]) | (&v[63:5]);
   assign fit8     = (~|v[63:7])  | (&v[63:7]);
   assign fit16    = (~|v[63:15]) | (&v[63:15]);
   assign fit32    = (~|v[63:31]) | (&v[63:31]);
   assign len_bad  = |v[63:32];
   assign len_lt32 = ~|v[31:5];
   assign len_le8  = ~|v[31:8];
   assign len_le16 = ~|v[31:16];

   always_comb begin
      drop   = 1'b0;
      header = v[7:0];
      count  = '0;
      case (req_operation)
         mve_pkg::OP_INT: begin
            if (fixint) begin
               header = v[7:0];
               count  = mve_pkg::CNT_W'(0);
            end else if (fit8) begin
               header = mve_pkg::HDR_INT8;
               count  = mve_pkg::CNT_W'(1);
            end else if (fit16) begin
               header = mve_pkg::HDR_INT16;
               count  = mve_pkg::CNT_W'(2);
            end else if (fit32) begin
               header = mve_pkg::HDR_INT32;
               count  = mve_pkg::CNT_W'(4);
            end else begin
               header = mve_pkg::HDR_INT64;
               count  = mve_pkg::CNT_W'(8);
            end
         end
         mve_pkg::OP_STR: begin
            drop = len_bad;
            if (len_lt32) begin
               header = mve_pkg::HDR_FIXSTR | {3'b000, v[4:0]};
               count  = mve_pkg::CNT_W'(0);
            end else if (len_le8) begin
               header = mve_pkg::HDR_STR8;
               count  = mve_pkg::CNT_W'(1);
            end else if (len_le16) begin
               header = mve_pkg::HDR_STR16;
               count  = mve_pkg::CNT_W'(2);
            end else begin
               header = mve_pkg::HDR_STR32;
               count  = mve_pkg::CNT_W'(4);
            end
         end
         mve_pkg::OP_BIN: begin
            drop = len_bad;
            if (len_le8) begin
               header = mve_pkg::HDR_BIN8;
               count  = mve_pkg::CNT_W'(1);
            end else if (len_le16) begin
               header = mve_pkg::HDR_BIN16;
               count  = mve_pkg::CNT_W'(2);
            end else begin
               header = mve_pkg::HDR_BIN32;
               count  = mve_pkg::CNT_W'(4);
            end
         end
         default: begin
            header = v[7:0];
            count  = '0;
         end
      endcase
   end

   // align payload so its first byte sits at the top
   always_comb begin
      push_desc.header = header;
      push_desc.count  = count;
      case (count)
         mve_pkg::CNT_W'(1): push_desc.payload = {v[7:0], 56'd0};
         mve_pkg::CNT_W'(2): push_desc.payload = {v[15:0], 48'd0};
         mve_pkg::CNT_W'(4): push_desc.payload = {v[31:0], 32'd0};
         default:            push_desc.payload = v;
      endcase
   end

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full & ~drop;

endmodule
`default_nettype wire

// File: hw/rtl/mve_queue.sv
`default_nettype none
module mve_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mve_pkg::desc_type push_desc,
   input  wire logic              pop,
   output mve_pkg::desc_type      head,
   output logic                   full,
   output logic                   empty
);

   mve_pkg::desc_type               mem_ff [mve_pkg::QDEPTH];
   logic [mve_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mve_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mve_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full  = (count_ff == mve_pkg::QCNT_W'(mve_pkg::QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mve_pkg::QPTR_W'(mve_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mve_pkg::QPTR_W'(mve_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not follow a lone write");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/mve_back.sv
`default_nettype none
module mve_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mve_pkg::desc_type head,
   input  wire logic              empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_byte
);

   logic                              valid_ff, valid_in;
   logic [mve_pkg::BYTE_W-1:0]        byte_ff, byte_in;
   logic                              last_ff, last_in;
   logic [mve_pkg::VALUE_W-1:0]       data_ff, data_in;
   logic [mve_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                              adv;

   assign adv = !valid_ff || !rsp_stall;
   assign pop = adv && (cnt_ff == '0) && !empty;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      cnt_in   = cnt_ff;
      if (adv) begin
         if (cnt_ff != '0) begin
            valid_in = 1'b1;
            byte_in  = data_ff[mve_pkg::VALUE_W-1 -: mve_pkg::BYTE_W];
            last_in  = (cnt_ff == mve_pkg::CNT_W'(1));
            data_in  = data_ff << mve_pkg::BYTE_W;
            cnt_in   = cnt_ff - 1'b1;
         end else if (!empty) begin
            valid_in = 1'b1;
            byte_in  = head.header;
            last_in  = (head.count == '0);
            data_in  = head.payload;
            cnt_in   = head.count;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      data_ff <= data_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

`ifndef NO_ASSERTIONS
   a_busy_has_word: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> valid_ff)
      else $error("payload pending without a word on the output");
   a_not_last_pending: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> (cnt_ff != '0))
      else $error("non-final word with nothing left to send");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte)))
      else $error("stalled output word changed");
`endif

endmodule
`default_nettype wire
